@@ rtl/rvp_pkg.sv @@
package rvp_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE_Q     = 1 << FRAC_BITS;
    localparam int MAX_DIM   = 4096;
    localparam int DIST_CAP  = 1 << 18;

    // Pipeline depths
    localparam int OFS_DIV_STEPS = 30;
    localparam int OFS_LAT       = OFS_DIV_STEPS + 4;
    localparam int SQRT_STEPS    = 19;
    localparam int SMOOTH_STEPS  = 13;
    localparam int PIPE_LAT      = OFS_LAT + 2 + SQRT_STEPS + 1 + SMOOTH_STEPS + 6;

    // Register map, indexed by paddr[4:2]
    localparam logic [2:0] REG_FRAME_W   = 3'd0;
    localparam logic [2:0] REG_FRAME_H   = 3'd1;
    localparam logic [2:0] REG_RADIUS    = 3'd2;
    localparam logic [2:0] REG_SOFTNESS  = 3'd3;
    localparam logic [2:0] REG_INTENSITY = 3'd4;
    localparam logic [2:0] REG_CENTER_X  = 3'd5;
    localparam logic [2:0] REG_CENTER_Y  = 3'd6;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] line;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_pix_out;

endpackage

@@ rtl/rvp_offset.sv @@
module rvp_offset (
    input  logic               i_clk,
    input  logic [11:0]        i_pos,
    input  logic signed [15:0] i_center,
    input  logic [12:0]        i_dim,
    input  logic [12:0]        i_min,
    output logic [18:0]        o_mag
);

    localparam int NW = rvp_pkg::OFS_DIV_STEPS;

    logic [24:0]        r_lhs;
    logic signed [29:0] r_prod;
    logic [28:0]        r_mag;
    logic [NW-1:0]      r_num;
    logic [30:0]        w_n;
    logic [30:0]        w_abs;

    logic [NW-1:0] r_n [0:NW];
    logic [NW-1:0] r_q [0:NW];
    logic [12:0]   r_r [0:NW];

    always_ff @(posedge i_clk) begin
        r_lhs  <= {i_pos, 1'b1, 12'b0};
        r_prod <= i_center * $signed({1'b0, i_dim});
    end

    // Numerator is (2*pos+1)*2^F - 2*centre*dim
    assign w_n   = {6'b0, r_lhs} - {r_prod, 1'b0};
    assign w_abs = w_n[30] ? (31'd0 - w_n) : w_n;

    always_ff @(posedge i_clk) begin
        r_mag <= w_abs[28:0];
        r_num <= {1'b0, r_mag} + {18'b0, i_min[12:1]};
    end

    assign r_n[0] = r_num;
    assign r_q[0] = '0;
    assign r_r[0] = '0;

    // One quotient bit per stage, restoring
    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [13:0] w_t;
        logic        w_ge;
        assign w_t  = {r_r[k], r_n[k][NW-1]};
        assign w_ge = w_t >= {1'b0, i_min};
        always_ff @(posedge i_clk) begin
            r_n[k+1] <= {r_n[k][NW-2:0], 1'b0};
            r_q[k+1] <= {r_q[k][NW-2:0], w_ge};
            r_r[k+1] <= w_ge ? 13'(w_t - {1'b0, i_min}) : w_t[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_q[NW] > NW'(rvp_pkg::DIST_CAP)) begin
            o_mag <= 19'(rvp_pkg::DIST_CAP);
        end else begin
            o_mag <= r_q[NW][18:0];
        end
    end

endmodule

@@ rtl/radial_vignette_pixel_top.sv @@
// Channel   | Handshake                          | Payload
// ----------+------------------------------------+-----------------------
// pixel in  | start, accepted when busy is low   | i_pixel (rvp_pkg::t_pix_in)
// pixel out | o_strobe, one cycle, no back-press | o_pixel (rvp_pkg::t_pix_out)
// config    | APB write/read, pready always high | pwdata / prdata
//
// One pixel per clock; busy never rises. A result passes through the two
// 30-step offset dividers, the 19-step square root and the 13-step
// smoothstep divider, one bit per stage each.
// Synchronous active-low reset clears the valid line, presets the registers.
// Registers may be written only while the pipeline is empty.
module radial_vignette_pixel_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rvp_pkg::t_pix_in  i_pixel,
    output logic              o_strobe,
    output rvp_pkg::t_pix_out o_pixel,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LAT   = rvp_pkg::PIPE_LAT;
    localparam int SQN   = rvp_pkg::SQRT_STEPS;
    localparam int SMN   = rvp_pkg::SMOOTH_STEPS;

    logic [12:0] r_frame_w, r_frame_h;
    logic [15:0] r_radius, r_softness, r_intensity;
    logic [15:0] r_center_x, r_center_y;
    logic [12:0] r_dim_w, r_dim_h, r_dim_m;
    logic [12:0] n_dim_w, n_dim_h;
    logic        w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w   <= 13'd1920;
            r_frame_h   <= 13'd1080;
            r_radius    <= 16'd3072;
            r_softness  <= 16'd1024;
            r_intensity <= 16'd0;
            r_center_x  <= 16'd2048;
            r_center_y  <= 16'd2048;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                rvp_pkg::REG_FRAME_W:   r_frame_w   <= pwdata[12:0];
                rvp_pkg::REG_FRAME_H:   r_frame_h   <= pwdata[12:0];
                rvp_pkg::REG_RADIUS:    r_radius    <= pwdata[15:0];
                rvp_pkg::REG_SOFTNESS:  r_softness  <= pwdata[15:0];
                rvp_pkg::REG_INTENSITY: r_intensity <= pwdata[15:0];
                rvp_pkg::REG_CENTER_X:  r_center_x  <= pwdata[15:0];
                rvp_pkg::REG_CENTER_Y:  r_center_y  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            rvp_pkg::REG_FRAME_W:   prdata = {19'b0, r_frame_w};
            rvp_pkg::REG_FRAME_H:   prdata = {19'b0, r_frame_h};
            rvp_pkg::REG_RADIUS:    prdata = {16'b0, r_radius};
            rvp_pkg::REG_SOFTNESS:  prdata = {16'b0, r_softness};
            rvp_pkg::REG_INTENSITY: prdata = {16'b0, r_intensity};
            rvp_pkg::REG_CENTER_X:  prdata = {16'b0, r_center_x};
            rvp_pkg::REG_CENTER_Y:  prdata = {16'b0, r_center_y};
            default:                prdata = '0;
        endcase
    end

    // Clamp dimensions to 1..MAX_DIM
    assign n_dim_w = (r_frame_w == 13'd0) ? 13'd1 :
                     (r_frame_w > 13'(rvp_pkg::MAX_DIM)) ? 13'(rvp_pkg::MAX_DIM) : r_frame_w;
    assign n_dim_h = (r_frame_h == 13'd0) ? 13'd1 :
                     (r_frame_h > 13'(rvp_pkg::MAX_DIM)) ? 13'(rvp_pkg::MAX_DIM) : r_frame_h;

    always_ff @(posedge i_clk) begin
        r_dim_w <= n_dim_w;
        r_dim_h <= n_dim_h;
        r_dim_m <= (n_dim_w < n_dim_h) ? n_dim_w : n_dim_h;
    end

    // Valid and pixel line alongside the datapath
    logic              r_vld [1:LAT-1];
    rvp_pkg::t_pix_in  r_pix [1:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[1] <= 1'b0;
        end else begin
            r_vld[1] <= start && !busy;
        end
        r_pix[1] <= i_pixel;
    end

    for (genvar k = 2; k < LAT; k++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
            r_pix[k] <= r_pix[k-1];
        end
    end

    logic [18:0] w_mag_x, w_mag_y;

    rvp_offset u_ofs_x (
        .i_clk    (i_clk),
        .i_pos    (i_pixel.column),
        .i_center (r_center_x),
        .i_dim    (r_dim_w),
        .i_min    (r_dim_m),
        .o_mag    (w_mag_x)
    );

    rvp_offset u_ofs_y (
        .i_clk    (i_clk),
        .i_pos    (i_pixel.line),
        .i_center (r_center_y),
        .i_dim    (r_dim_h),
        .i_min    (r_dim_m),
        .o_mag    (w_mag_y)
    );

    logic [37:0] r_sqx, r_sqy, r_sq;

    always_ff @(posedge i_clk) begin
        r_sqx <= {19'b0, w_mag_x} * {19'b0, w_mag_x};
        r_sqy <= {19'b0, w_mag_y} * {19'b0, w_mag_y};
        r_sq  <= r_sqx + r_sqy;
    end

    // Square root, two radicand bits per stage
    logic [37:0] r_rad  [0:SQN];
    logic [20:0] r_rem  [0:SQN];
    logic [18:0] r_root [0:SQN];

    assign r_rad[0]  = r_sq;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        logic [22:0] w_cur;
        logic [22:0] w_trial;
        logic        w_ge;
        assign w_cur   = {r_rem[k], r_rad[k][37:36]};
        assign w_trial = {2'b0, r_root[k], 2'b01};
        assign w_ge    = w_cur >= w_trial;
        always_ff @(posedge i_clk) begin
            r_rad[k+1]  <= {r_rad[k][35:0], 2'b00};
            r_rem[k+1]  <= w_ge ? 21'(w_cur - w_trial) : w_cur[20:0];
            r_root[k+1] <= {r_root[k][17:0], w_ge};
        end
    end

    // Smoothstep band test and division set-up
    logic [16:0] w_b;
    logic [18:0] w_diff;
    logic [28:0] r_snum [0:SMN];
    logic [12:0] r_u    [0:SMN];
    logic        r_le   [0:SMN];
    logic        r_ge   [0:SMN];

    assign w_b    = {1'b0, r_radius} + {1'b0, r_softness};
    assign w_diff = r_root[SQN] - {3'b0, r_radius};

    always_ff @(posedge i_clk) begin
        r_le[0]   <= r_root[SQN] <= {3'b0, r_radius};
        r_ge[0]   <= r_root[SQN] >= {2'b0, w_b};
        r_snum[0] <= {1'b0, w_diff[15:0], 12'b0} + {14'b0, r_softness[15:1]};
        r_u[0]    <= '0;
    end

    for (genvar k = 0; k < SMN; k++) begin : g_smooth
        logic [28:0] w_span;
        logic        w_ge;
        assign w_span = {13'b0, r_softness} << (SMN - 1 - k);
        assign w_ge   = r_snum[k] >= w_span;
        always_ff @(posedge i_clk) begin
            r_snum[k+1] <= w_ge ? (r_snum[k] - w_span) : r_snum[k];
            r_u[k+1]    <= {r_u[k][11:0], w_ge};
            r_le[k+1]   <= r_le[k];
            r_ge[k+1]   <= r_ge[k];
        end
    end

    logic [24:0] r_uu;
    logic [13:0] r_w;
    logic        r_le2, r_ge2, r_le3, r_ge3;
    logic [38:0] r_cub;
    logic [12:0] r_t;
    logic [28:0] r_ip;
    logic [12:0] r_factor;
    logic [16:0] w_p;
    logic [12:0] w_u;

    assign w_u = (r_u[SMN] > 13'(rvp_pkg::ONE_Q)) ? 13'(rvp_pkg::ONE_Q) : r_u[SMN];
    assign w_p = 17'((r_ip + 29'd2048) >> rvp_pkg::FRAC_BITS);

    always_ff @(posedge i_clk) begin
        r_uu     <= 25'({12'b0, w_u} * {12'b0, w_u});
        r_w      <= 14'(3 * rvp_pkg::ONE_Q) - {w_u, 1'b0};
        r_le2    <= r_le[SMN];
        r_ge2    <= r_ge[SMN];
        r_cub    <= {14'b0, r_uu} * {25'b0, r_w};
        r_le3    <= r_le2;
        r_ge3    <= r_ge2;
        priority if (r_le3) begin
            r_t <= '0;
        end else if (r_ge3) begin
            r_t <= 13'(rvp_pkg::ONE_Q);
        end else begin
            r_t <= 13'((r_cub + 39'(1 << (2 * rvp_pkg::FRAC_BITS - 1)))
                       >> (2 * rvp_pkg::FRAC_BITS));
        end
        r_ip     <= {13'b0, r_intensity} * {16'b0, r_t};
        r_factor <= (w_p >= 17'(rvp_pkg::ONE_Q)) ? 13'd0 : 13'(17'(rvp_pkg::ONE_Q) - w_p);
    end

    function automatic logic [7:0] scale_chan(input logic [7:0] v, input logic [12:0] f);
        logic [20:0] r;
        r = ({13'b0, v} * {8'b0, f} + 21'd2048) >> rvp_pkg::FRAC_BITS;
        priority if (f == 13'd0) begin
            return 8'd0;
        end else if (f >= 13'(rvp_pkg::ONE_Q)) begin
            return v;
        end else if (r > 21'd255) begin
            return 8'd255;
        end else begin
            return r[7:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_vld[LAT-1];
        end
        o_pixel.red_out   <= scale_chan(r_pix[LAT-1].red, r_factor);
        o_pixel.green_out <= scale_chan(r_pix[LAT-1].green, r_factor);
        o_pixel.blue_out  <= scale_chan(r_pix[LAT-1].blue, r_factor);
        o_pixel.alpha_out <= r_pix[LAT-1].alpha;
    end

`ifndef NO_ASSERTIONS
    a_busy_low: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result without a transfer");

    a_alpha_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_pixel.alpha_out == $past(i_pixel.alpha, LAT))
        else $error("alpha misaligned");

    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAT-1] |-> r_factor <= 13'(rvp_pkg::ONE_Q))
        else $error("factor above one");
`endif

endmodule

@@ verif/tb_radial_vignette_pixel_top.sv @@
`timescale 1ns / 100ps

module tb_radial_vignette_pixel_top;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    rvp_pkg::t_pix_in  i_pixel;
    logic              o_strobe;
    rvp_pkg::t_pix_out o_pixel;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    radial_vignette_pixel_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pixel  (i_pixel),
        .o_strobe (o_strobe),
        .o_pixel  (o_pixel),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the block's registers
    logic [12:0]        frame_w;
    logic [12:0]        frame_h;
    logic [15:0]        radius;
    logic [15:0]        softness;
    logic [15:0]        intensity;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;

    rvp_pkg::t_pix_in  pixel_queue[$];
    rvp_pkg::t_pix_out shaded_queue[$];
    int                error_count;
    int                send_idle_pct;
    logic              feed_enable;

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    function automatic longint pixel_offset(logic [11:0] pos, logic signed [15:0] ctr,
                                            longint dim, longint m);
        longint num;
        longint mag;
        longint q;
        num = ((2 * longint'(pos) + 1) <<< rvp_pkg::FRAC_BITS) - 2 * longint'(ctr) * dim;
        mag = (num < 0) ? -num : num;
        q = (mag + m / 2) / m;
        if (q > rvp_pkg::DIST_CAP) q = rvp_pkg::DIST_CAP;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 1 << 20;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [7:0] darken(logic [7:0] v, longint factor);
        longint r;
        if (factor == 0) return 8'd0;
        if (factor >= rvp_pkg::ONE_Q) return v;
        r = (longint'(v) * factor + rvp_pkg::ONE_Q / 2) >>> rvp_pkg::FRAC_BITS;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic rvp_pkg::t_pix_out shade_pixel(rvp_pkg::t_pix_in px);
        longint            w;
        longint            h;
        longint            m;
        longint            dx;
        longint            dy;
        longint            dist_q;
        longint            lo_r;
        longint            hi_r;
        longint            span;
        longint            u;
        longint            t;
        longint            p;
        longint            factor;
        rvp_pkg::t_pix_out res;
        w = (frame_w < 1) ? 1 : (frame_w > rvp_pkg::MAX_DIM) ? rvp_pkg::MAX_DIM : frame_w;
        h = (frame_h < 1) ? 1 : (frame_h > rvp_pkg::MAX_DIM) ? rvp_pkg::MAX_DIM : frame_h;
        m = (w < h) ? w : h;
        dx = pixel_offset(px.column, centre_x, w, m);
        dy = pixel_offset(px.line, centre_y, h, m);
        dist_q = int_sqrt(dx * dx + dy * dy);
        lo_r = radius;
        hi_r = lo_r + softness;
        if (dist_q <= lo_r) t = 0;
        else if (dist_q >= hi_r) t = rvp_pkg::ONE_Q;
        else begin
            span = hi_r - lo_r;
            u = (((dist_q - lo_r) <<< rvp_pkg::FRAC_BITS) + span / 2) / span;
            if (u > rvp_pkg::ONE_Q) u = rvp_pkg::ONE_Q;
            t = (u * u * (3 * rvp_pkg::ONE_Q - 2 * u)
                 + (longint'(1) <<< (2 * rvp_pkg::FRAC_BITS - 1)))
                >>> (2 * rvp_pkg::FRAC_BITS);
        end
        p = (longint'(intensity) * t + rvp_pkg::ONE_Q / 2) >>> rvp_pkg::FRAC_BITS;
        factor = (p >= rvp_pkg::ONE_Q) ? 0 : rvp_pkg::ONE_Q - p;
        res.red_out   = darken(px.red, factor);
        res.green_out = darken(px.green, factor);
        res.blue_out  = darken(px.blue, factor);
        res.alpha_out = px.alpha;
        return res;
    endfunction

    // driver: hold start while the same pixel waits, advance on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                shaded_queue.push_back(shade_pixel(i_pixel));
                void'(pixel_queue.pop_front());
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (feed_enable && pixel_queue.size() > 0
                         && $urandom_range(99) >= send_idle_pct) begin
                start   <= 1'b1;
                i_pixel <= pixel_queue[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        rvp_pkg::t_pix_out exp_px;
        if (i_rst_n && o_strobe) begin
            if (shaded_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_pixel);
                error_count++;
            end else begin
                exp_px = shaded_queue.pop_front();
                if (o_pixel.red_out !== exp_px.red_out)
                    $display("%0t: red exp %h got %h", $time, exp_px.red_out, o_pixel.red_out);
                if (o_pixel.green_out !== exp_px.green_out)
                    $display("%0t: green exp %h got %h", $time, exp_px.green_out,
                             o_pixel.green_out);
                if (o_pixel.blue_out !== exp_px.blue_out)
                    $display("%0t: blue exp %h got %h", $time, exp_px.blue_out,
                             o_pixel.blue_out);
                if (o_pixel.alpha_out !== exp_px.alpha_out)
                    $display("%0t: alpha exp %h got %h", $time, exp_px.alpha_out,
                             o_pixel.alpha_out);
                if (o_pixel !== exp_px) error_count++;
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rvp_pkg::REG_FRAME_W:   frame_w   = value[12:0];
            rvp_pkg::REG_FRAME_H:   frame_h   = value[12:0];
            rvp_pkg::REG_RADIUS:    radius    = value[15:0];
            rvp_pkg::REG_SOFTNESS:  softness  = value[15:0];
            rvp_pkg::REG_INTENSITY: intensity = value[15:0];
            rvp_pkg::REG_CENTER_X:  centre_x  = value[15:0];
            rvp_pkg::REG_CENTER_Y:  centre_y  = value[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0 || start || shaded_queue.size() != 0)
            @(posedge i_clk);
        repeat (rvp_pkg::PIPE_LAT + 5) @(posedge i_clk);
    endtask

    task automatic add_pixel(int col, int lin);
        rvp_pkg::t_pix_in px;
        px.column = col[11:0];
        px.line   = lin[11:0];
        px.red    = $urandom();
        px.green  = $urandom();
        px.blue   = $urandom();
        px.alpha  = $urandom();
        pixel_queue.push_back(px);
    endtask

    task automatic random_pixels(int count);
        int w;
        int h;
        w = (frame_w == 0) ? 1 : frame_w;
        h = (frame_h == 0) ? 1 : frame_h;
        repeat (count) begin
            if ($urandom_range(9) == 0)
                add_pixel($urandom_range(4095), $urandom_range(4095));
            else
                add_pixel($urandom_range((w > 4096 ? 4096 : w) - 1),
                          $urandom_range((h > 4096 ? 4096 : h) - 1));
        end
    endtask

    task automatic random_settings();
        reg_write(rvp_pkg::REG_FRAME_W,   $urandom_range(1, 64));
        reg_write(rvp_pkg::REG_FRAME_H,   $urandom_range(1, 64));
        reg_write(rvp_pkg::REG_RADIUS,    $urandom_range(8192));
        reg_write(rvp_pkg::REG_SOFTNESS,  ($urandom_range(4) == 0) ? 0 : $urandom_range(8192));
        reg_write(rvp_pkg::REG_INTENSITY,
                  ($urandom_range(5) == 0) ? $urandom() : $urandom_range(8192));
        reg_write(rvp_pkg::REG_CENTER_X,  $urandom_range(6144) - 1024);
        reg_write(rvp_pkg::REG_CENTER_Y,  $urandom_range(6144) - 1024);
    endtask

    initial begin
        error_count   = 0;
        send_idle_pct = 32;
        feed_enable   = 1'b0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_pixel = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        frame_w = 13'd1920;
        frame_h = 13'd1080;
        radius = 16'd3072;
        softness = 16'd1024;
        intensity = 16'd0;
        centre_x = 16'sd2048;
        centre_y = 16'sd2048;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, then extremes of the coordinates
        feed_enable = 1'b1;
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(960, 540);
        drain();
        reg_write(rvp_pkg::REG_INTENSITY, 32'd4096);
        add_pixel(0, 0);
        add_pixel(1919, 1079);
        add_pixel(4095, 0);
        add_pixel(0, 4095);
        pixel_queue.push_back('{12'd100, 12'd100, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        pixel_queue.push_back('{12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00});
        drain();
        // zero dimensions, zero softness, huge intensity
        reg_write(rvp_pkg::REG_FRAME_W, 32'd0);
        reg_write(rvp_pkg::REG_FRAME_H, 32'd0);
        reg_write(rvp_pkg::REG_SOFTNESS, 32'd0);
        reg_write(rvp_pkg::REG_INTENSITY, 32'hFFFF);
        add_pixel(0, 0);
        add_pixel(1, 0);
        add_pixel(4095, 4095);
        drain();
        // oversized dimensions, extreme centres and radius
        reg_write(rvp_pkg::REG_FRAME_W, 32'h1FFF);
        reg_write(rvp_pkg::REG_FRAME_H, 32'd4096);
        reg_write(rvp_pkg::REG_RADIUS, 32'hFFFF);
        reg_write(rvp_pkg::REG_SOFTNESS, 32'hFFFF);
        reg_write(rvp_pkg::REG_CENTER_X, 32'h8000);
        reg_write(rvp_pkg::REG_CENTER_Y, 32'h7FFF);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(2048, 2048);
        drain();
        reg_write(rvp_pkg::REG_RADIUS, 32'd0);
        reg_write(rvp_pkg::REG_SOFTNESS, 32'd2048);
        reg_write(rvp_pkg::REG_CENTER_X, 32'h7FFF);
        reg_write(rvp_pkg::REG_CENTER_Y, 32'h8000);
        reg_write(rvp_pkg::REG_INTENSITY, 32'd8192);
        add_pixel(0, 4095);
        add_pixel(4095, 0);
        add_pixel(17, 33);
        drain();
        // write to an unmapped register must be ignored
        reg_write(3'd7, 32'hFFFF_FFFF);
        add_pixel(5, 5);
        drain();

        for (int phase = 0; phase < 18; phase++) begin
            send_idle_pct = (phase < 6) ? 32 : (phase < 12) ? 76 : 0;
            random_settings();
            random_pixels(95);
            drain();
        end

        feed_enable = 1'b0;
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
